>>> design/fnt_pkg.sv
package fnt_pkg;

   // defaults for the top-level parameters
   localparam int PROB_SCALE_BITS_DEF = 12;
   localparam int MAX_SYMS_DEF        = 256;
   localparam int MIN_SYMS_DEF        = 2;

   // fixed payload widths
   localparam int FREQ_W   = 32;
   localparam int INDEX_W  = 9;
   localparam int STATUS_W = 2;
   localparam int CUM_W    = 13;
   localparam int TOTAL_W  = 40;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 2'd0,
      STAT_BAD_COUNT = 2'd1,
      STAT_NO_SYMBOL = 2'd2,
      STAT_OVERFLOW  = 2'd3
   } status_type;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_READ = 1'b1
   } action_type;

endpackage

>>> design/fnt_ifs.sv
// request channel: load a frequency or read a table entry
interface fnt_req_if;
   logic                       valid;
   logic                       ready;
   logic                       action;
   logic [fnt_pkg::FREQ_W-1:0]  frequency;
   logic                       last_load;
   logic [fnt_pkg::INDEX_W-1:0] read_index;

   modport source (output valid, action, frequency, last_load, read_index, input ready);
   modport sink   (input valid, action, frequency, last_load, read_index, output ready);
endinterface

// response channel: status and one table entry
interface fnt_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [fnt_pkg::STATUS_W-1:0] status;
   logic [fnt_pkg::CUM_W-1:0]    cum_start;
   logic [fnt_pkg::CUM_W-1:0]    scaled_freq;
   logic [fnt_pkg::FREQ_W-1:0]   adjusted_freq;

   modport source (output valid, status, cum_start, scaled_freq, adjusted_freq, input ready);
   modport sink   (input valid, status, cum_start, scaled_freq, adjusted_freq, output ready);
endinterface

>>> design/frequency_table_normalizer_top.sv
// Channel   Dir  Handshake    Payload
// req_chan  in   valid/ready  action, frequency, last_load, read_index
// rsp_chan  out  valid/ready  status, cum_start, scaled_freq, adjusted_freq
//
// A load without last_load gives no transfer on rsp_chan. A read passes through
// ST_RD and ST_OUT to the result register. A closing load runs the normalizer:
// a count of used symbols, scale rounds, and one or two passes over the symbols
// that divide freq*scale by total for each used one in the bit-serial restoring
// divider.
// req_chan.ready is high only in the idle state; reset is synchronous and clears
// all control state. A stalled rsp_chan holds the result register.
module frequency_table_normalizer_top #(
   parameter int PROB_SCALE_BITS = fnt_pkg::PROB_SCALE_BITS_DEF,
   parameter int MAX_SYMS        = fnt_pkg::MAX_SYMS_DEF,
   parameter int MIN_SYMS        = fnt_pkg::MIN_SYMS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   fnt_req_if.sink   req_chan,
   fnt_rsp_if.source rsp_chan
);

   localparam int SW  = PROB_SCALE_BITS + 1;
   localparam int CIW = SW + 1;
   localparam int AW  = (MAX_SYMS > 1) ? $clog2(MAX_SYMS) : 1;
   localparam int CW  = $clog2(MAX_SYMS + 1);
   localparam int RW  = $clog2(MAX_SYMS + 2);
   localparam int KW  = $clog2(SW);
   localparam int FW  = fnt_pkg::FREQ_W;
   localparam int TW  = fnt_pkg::TOTAL_W;
   localparam int DW  = TW + SW;
   localparam int OW  = fnt_pkg::CUM_W;
   localparam int XW  = (SW > OW) ? SW : OW;
   localparam int IW  = fnt_pkg::INDEX_W;
   localparam logic [SW-1:0] FULL       = {1'b1, {PROB_SCALE_BITS{1'b0}}};
   localparam logic [RW-1:0] ROUND_LAST = RW'(MAX_SYMS + 1);
   localparam logic [CW-1:0] COUNT_MAX  = CW'(MAX_SYMS);
   localparam logic [KW-1:0] K_TOP      = KW'(SW - 1);

   typedef enum logic [13:0] {
      ST_IDLE      = 14'b00000000000001,
      ST_CHK       = 14'b00000000000010,
      ST_CNT       = 14'b00000000000100,
      ST_CNT_END   = 14'b00000000001000,
      ST_TRM_START = 14'b00000000010000,
      ST_TRM_MUL   = 14'b00000000100000,
      ST_TRM_CMP   = 14'b00000001000000,
      ST_TRM_END   = 14'b00000010000000,
      ST_PS_MUL    = 14'b00000100000000,
      ST_PS_DIV    = 14'b00001000000000,
      ST_PS_ADD    = 14'b00010000000000,
      ST_PS_END    = 14'b00100000000000,
      ST_RD        = 14'b01000000000000,
      ST_OUT       = 14'b10000000000000
   } state_type;

   state_type           state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [TW-1:0]       total_ff, total_in;
   logic                too_many_ff, too_many_in;
   logic                closed_ff, closed_in;
   logic                tbl_ready_ff, tbl_ready_in;
   fnt_pkg::status_type last_status_ff, last_status_in;
   logic [CW-1:0]       used_ff, used_in;
   logic [AW-1:0]       fz_ff, fz_in;
   logic                fz_found_ff, fz_found_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [SW-1:0]       scale_ff, scale_in;
   logic [RW-1:0]       round_ff, round_in;
   logic [CW-1:0]       trunc_ff, trunc_in;
   logic [DW-1:0]       rem_ff, rem_in;
   logic [SW-1:0]       q_ff, q_in;
   logic [KW-1:0]       k_ff, k_in;
   logic [CIW-1:0]      ci_ff, ci_in;
   logic [FW-1:0]       best_f_ff, best_f_in;
   logic [AW-1:0]       best_i_ff, best_i_in;
   logic [AW-1:0]       boost_i_ff, boost_i_in;
   logic [SW-1:0]       boost_ff, boost_in;
   logic                pass_ff, pass_in;
   logic                rd_hit_ff, rd_hit_in;
   logic                rd_cnt_ff, rd_cnt_in;
   fnt_pkg::status_type pst_ff, pst_in;
   logic [OW-1:0]       pcum_ff, pcum_in;
   logic [OW-1:0]       psc_ff, psc_in;
   logic [FW-1:0]       padj_ff, padj_in;
   logic                rsp_valid_ff, rsp_valid_in;
   fnt_pkg::status_type ost_ff, ost_in;
   logic [OW-1:0]       ocum_ff, ocum_in;
   logic [OW-1:0]       osc_ff, osc_in;
   logic [FW-1:0]       oadj_ff, oadj_in;

   // memories and their registered read data
   logic [FW-1:0]       freq_mem [MAX_SYMS];
   logic [SW-1:0]       cum_mem  [MAX_SYMS+1];
   logic [FW-1:0]       fq_rd_ff;
   logic [SW-1:0]       ca_rd_ff, cb_rd_ff;
   logic                fq_we, cm_we;
   logic [AW-1:0]       fq_wa;
   logic [FW-1:0]       fq_wd;
   logic [SW-1:0]       cm_wd;
   logic [CW-1:0]       cb_addr;

   // shared datapath terms
   logic                accept;
   logic                last_idx;
   logic [CW-1:0]       load_cnt;
   logic [DW-1:0]       div_sub;
   logic [SW-1:0]       hi_lim, share_l;
   logic [SW-1:0]       next_scale;
   logic [CIW-1:0]      ci_sum;
   logic                fin;
   fnt_pkg::status_type fin_st;
   logic [XW-1:0]       ca_x, diff_x, full_x;

   assign accept    = req_chan.valid && req_chan.ready;
   assign last_idx  = (idx_ff == count_ff - CW'(1));
   assign load_cnt  = closed_ff ? '0 : count_ff;
   assign div_sub   = DW'(total_ff) << k_ff;
   assign hi_lim    = FULL - SW'(used_ff - CW'(1));
   assign next_scale = FULL - SW'(trunc_ff);
   assign cb_addr   = (idx_in == COUNT_MAX) ? idx_in : idx_in + CW'(1);
   assign ca_x      = XW'(ca_rd_ff);
   assign diff_x    = XW'(cb_rd_ff - ca_rd_ff);
   assign full_x    = XW'(FULL);

   // clamp the quotient to [1, hi] and add the shortfall on the boosted symbol
   always_comb begin
      share_l = q_ff;
      if (q_ff == '0) begin
         share_l = SW'(1);
      end
      if (share_l > hi_lim) begin
         share_l = hi_lim;
      end
      ci_sum = ci_ff + CIW'(share_l);
      if (pass_ff && (idx_ff[AW-1:0] == boost_i_ff)) begin
         ci_sum = ci_sum + CIW'(boost_ff);
      end
   end

   // memories: one write port, registered reads at the next index
   always_ff @(posedge clock) begin
      if (fq_we) begin
         freq_mem[fq_wa] <= fq_wd;
      end
      fq_rd_ff <= freq_mem[idx_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cm_we) begin
         cum_mem[idx_ff] <= cm_wd;
      end
      ca_rd_ff <= cum_mem[idx_in];
      cb_rd_ff <= cum_mem[cb_addr];
   end

   // sequencer
   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      total_in       = total_ff;
      too_many_in    = too_many_ff;
      closed_in      = closed_ff;
      tbl_ready_in   = tbl_ready_ff;
      last_status_in = last_status_ff;
      used_in        = used_ff;
      fz_in          = fz_ff;
      fz_found_in    = fz_found_ff;
      idx_in         = idx_ff;
      scale_in       = scale_ff;
      round_in       = round_ff;
      trunc_in       = trunc_ff;
      rem_in         = rem_ff;
      q_in           = q_ff;
      k_in           = k_ff;
      ci_in          = ci_ff;
      best_f_in      = best_f_ff;
      best_i_in      = best_i_ff;
      boost_i_in     = boost_i_ff;
      boost_in       = boost_ff;
      pass_in        = pass_ff;
      rd_hit_in      = rd_hit_ff;
      rd_cnt_in      = rd_cnt_ff;
      pst_in         = pst_ff;
      pcum_in        = pcum_ff;
      psc_in         = psc_ff;
      padj_in        = padj_ff;
      fq_we          = 1'b0;
      fq_wa          = count_ff[AW-1:0];
      fq_wd          = req_chan.frequency;
      cm_we          = 1'b0;
      cm_wd          = ci_ff[SW-1:0];
      fin            = 1'b0;
      fin_st         = fnt_pkg::STAT_OK;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept && (req_chan.action == fnt_pkg::ACT_LOAD)) begin
               // a load after a closed table starts a new one
               if (closed_ff) begin
                  total_in       = '0;
                  used_in        = '0;
                  last_status_in = fnt_pkg::STAT_OK;
                  closed_in      = 1'b0;
                  tbl_ready_in   = 1'b0;
                  too_many_in    = 1'b0;
               end
               if (load_cnt < COUNT_MAX) begin
                  fq_we    = 1'b1;
                  fq_wa    = load_cnt[AW-1:0];
                  count_in = load_cnt + CW'(1);
                  total_in = (closed_ff ? '0 : total_ff) + TW'(req_chan.frequency);
               end else begin
                  count_in    = load_cnt;
                  too_many_in = 1'b1;
               end
               if (req_chan.last_load) begin
                  state_in = ST_CHK;
               end
            end else if (accept) begin
               rd_hit_in   = (req_chan.read_index < IW'(count_ff));
               rd_cnt_in   = (req_chan.read_index == IW'(count_ff));
               idx_in      = (req_chan.read_index < IW'(count_ff)) ?
                             req_chan.read_index[CW-1:0] : '0;
               state_in    = ST_RD;
            end
         end

         ST_CHK: begin
            scale_in = FULL;
            if (too_many_ff || (IW'(count_ff) < IW'(MIN_SYMS)) || (count_ff > COUNT_MAX)) begin
               fin    = 1'b1;
               fin_st = fnt_pkg::STAT_BAD_COUNT;
            end else begin
               idx_in      = '0;
               used_in     = '0;
               fz_found_in = 1'b0;
               state_in    = ST_CNT;
            end
         end

         // count used symbols, note the first unused one
         ST_CNT: begin
            if (fq_rd_ff != '0) begin
               used_in = used_ff + CW'(1);
            end else if (!fz_found_ff) begin
               fz_in       = idx_ff[AW-1:0];
               fz_found_in = 1'b1;
            end
            if (last_idx) begin
               state_in = ST_CNT_END;
            end else begin
               idx_in = idx_ff + CW'(1);
            end
         end

         ST_CNT_END: begin
            if (used_ff == '0) begin
               fin    = 1'b1;
               fin_st = fnt_pkg::STAT_NO_SYMBOL;
            end else begin
               if (used_ff == CW'(1)) begin
                  // single used symbol: first unused one gets a count of 1
                  if (fz_found_ff) begin
                     fq_we    = 1'b1;
                     fq_wa    = fz_ff;
                     fq_wd    = FW'(1);
                     total_in = total_ff + TW'(1);
                  end
                  used_in = used_ff + CW'(1);
               end
               idx_in   = '0;
               round_in = '0;
               trunc_in = '0;
               state_in = ST_TRM_START;
            end
         end

         // a wait state so the read sees the fix-up write
         ST_TRM_START: begin
            state_in = ST_TRM_MUL;
         end

         ST_TRM_MUL: begin
            rem_in   = DW'(fq_rd_ff * scale_ff);
            state_in = ST_TRM_CMP;
         end

         // share truncates to zero when freq*scale < total
         ST_TRM_CMP: begin
            if ((fq_rd_ff != '0) && (rem_ff < DW'(total_ff))) begin
               trunc_in = trunc_ff + CW'(1);
            end
            if (last_idx) begin
               state_in = ST_TRM_END;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_TRM_MUL;
            end
         end

         ST_TRM_END: begin
            idx_in   = '0;
            trunc_in = '0;
            if ((trunc_ff == '0) || (next_scale == scale_ff)) begin
               state_in = ST_PS_MUL;
            end else begin
               scale_in = next_scale;
               if (round_ff == ROUND_LAST) begin
                  state_in = ST_PS_MUL;
               end else begin
                  round_in = round_ff + RW'(1);
                  state_in = ST_TRM_MUL;
               end
            end
            ci_in     = '0;
            best_f_in = '0;
            best_i_in = '0;
            pass_in   = 1'b0;
         end

         // record the start, track the largest, start the share
         ST_PS_MUL: begin
            cm_we = 1'b1;
            if (fq_rd_ff == '0) begin
               if (last_idx) begin
                  idx_in   = count_ff;
                  state_in = ST_PS_END;
               end else begin
                  idx_in = idx_ff + CW'(1);
               end
            end else begin
               if (fq_rd_ff > best_f_ff) begin
                  best_f_in = fq_rd_ff;
                  best_i_in = idx_ff[AW-1:0];
               end
               rem_in   = DW'(fq_rd_ff * scale_ff);
               q_in     = '0;
               k_in     = K_TOP;
               state_in = ST_PS_DIV;
            end
         end

         // restoring divide by total, one quotient bit a cycle
         ST_PS_DIV: begin
            if (rem_ff >= div_sub) begin
               rem_in     = rem_ff - div_sub;
               q_in[k_ff] = 1'b1;
            end
            if (k_ff == '0) begin
               state_in = ST_PS_ADD;
            end else begin
               k_in = k_ff - KW'(1);
            end
         end

         ST_PS_ADD: begin
            ci_in = ci_sum;
            if (ci_sum > CIW'(FULL)) begin
               fin    = 1'b1;
               fin_st = fnt_pkg::STAT_OVERFLOW;
            end else if (last_idx) begin
               idx_in   = count_ff;
               state_in = ST_PS_END;
            end else begin
               idx_in   = idx_ff + CW'(1);
               state_in = ST_PS_MUL;
            end
         end

         ST_PS_END: begin
            cm_we = 1'b1;
            cm_wd = FULL;
            if (ci_ff == CIW'(FULL)) begin
               fin    = 1'b1;
               fin_st = fnt_pkg::STAT_OK;
            end else if (pass_ff) begin
               fin    = 1'b1;
               fin_st = fnt_pkg::STAT_OVERFLOW;
            end else begin
               // second pass with the shortfall on the most frequent symbol
               boost_i_in = best_i_ff;
               boost_in   = FULL - ci_ff[SW-1:0];
               pass_in    = 1'b1;
               ci_in      = '0;
               best_f_in  = '0;
               best_i_in  = '0;
               idx_in     = '0;
               state_in   = ST_PS_MUL;
            end
         end

         ST_RD: begin
            pst_in  = last_status_ff;
            pcum_in = '0;
            psc_in  = '0;
            padj_in = '0;
            if (rd_hit_ff) begin
               padj_in = fq_rd_ff;
               if (tbl_ready_ff) begin
                  pcum_in = ca_x[OW-1:0];
                  psc_in  = diff_x[OW-1:0];
               end
            end else if (rd_cnt_ff && tbl_ready_ff) begin
               pcum_in = full_x[OW-1:0];
            end
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // closing a table: status result with zero entry fields
      if (fin) begin
         last_status_in = fin_st;
         closed_in      = 1'b1;
         tbl_ready_in   = (fin_st == fnt_pkg::STAT_OK);
         pst_in         = fin_st;
         pcum_in        = '0;
         psc_in         = '0;
         padj_in        = '0;
         state_in       = ST_OUT;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      ost_in       = ost_ff;
      ocum_in      = ocum_ff;
      osc_in       = osc_ff;
      oadj_in      = oadj_ff;
      if ((state_ff == ST_OUT) && (!rsp_valid_ff || rsp_chan.ready)) begin
         rsp_valid_in = 1'b1;
         ost_in       = pst_ff;
         ocum_in      = pcum_ff;
         osc_in       = psc_ff;
         oadj_in      = padj_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         count_ff       <= '0;
         total_ff       <= '0;
         too_many_ff    <= 1'b0;
         closed_ff      <= 1'b0;
         tbl_ready_ff   <= 1'b0;
         last_status_ff <= fnt_pkg::STAT_OK;
         used_ff        <= '0;
         scale_ff       <= FULL;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         count_ff       <= count_in;
         total_ff       <= total_in;
         too_many_ff    <= too_many_in;
         closed_ff      <= closed_in;
         tbl_ready_ff   <= tbl_ready_in;
         last_status_ff <= last_status_in;
         used_ff        <= used_in;
         scale_ff       <= scale_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      fz_ff       <= fz_in;
      fz_found_ff <= fz_found_in;
      idx_ff      <= idx_in;
      round_ff    <= round_in;
      trunc_ff    <= trunc_in;
      rem_ff      <= rem_in;
      q_ff        <= q_in;
      k_ff        <= k_in;
      ci_ff       <= ci_in;
      best_f_ff   <= best_f_in;
      best_i_ff   <= best_i_in;
      boost_i_ff  <= boost_i_in;
      boost_ff    <= boost_in;
      pass_ff     <= pass_in;
      rd_hit_ff   <= rd_hit_in;
      rd_cnt_ff   <= rd_cnt_in;
      pst_ff      <= pst_in;
      pcum_ff     <= pcum_in;
      psc_ff      <= psc_in;
      padj_ff     <= padj_in;
      ost_ff      <= ost_in;
      ocum_ff     <= ocum_in;
      osc_ff      <= osc_in;
      oadj_ff     <= oadj_in;
   end

   assign req_chan.ready         = (state_ff == ST_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = ost_ff;
   assign rsp_chan.cum_start     = ocum_ff;
   assign rsp_chan.scaled_freq   = osc_ff;
   assign rsp_chan.adjusted_freq = oadj_ff;

   // a normalized table always carries an ok status
   a_ready_ok: assert property (@(posedge clock) disable iff (reset)
      tbl_ready_ff |-> (last_status_ff == fnt_pkg::STAT_OK))
      else $error("table ready with a failing status");

   // the running start never exceeds full scale while a pass walks the table
   a_ci_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PS_MUL) |-> (ci_ff <= CIW'(FULL)))
      else $error("cumulative start beyond full scale");

   // a share can never be larger than the scale it was taken from
   a_q_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PS_ADD) |-> (q_ff <= scale_ff))
      else $error("share exceeds working scale");

   // a read result reports the status of the last table
   a_rd_status: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD) |=> (pst_ff == last_status_ff))
      else $error("read result status differs from table status");

   // the truncation count covers at most the loaded symbols
   a_trunc_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TRM_END) |-> (trunc_ff <= count_ff))
      else $error("truncation count beyond symbol count");

endmodule
